// File: design/ddes_pkg.sv
// Shared types and constants for the dual detector exposure sequencer.
// Holds the event and result word layouts, the register file and the state codes.
// No dependencies.
package ddes_pkg;

  // Event codes carried in the opcode field.
  typedef enum logic [3:0] {
    OP_TICK      = 4'd0,
    OP_START     = 4'd1,
    OP_CONNECT   = 4'd2,
    OP_PREP_DONE = 4'd3,
    OP_SHOT_ON   = 4'd4,
    OP_SHOT_OFF  = 4'd5,
    OP_DATA_DONE = 4'd6,
    OP_AFTER     = 4'd7,
    OP_SW1_ON    = 4'd8,
    OP_SW1_OFF   = 4'd9,
    OP_SW2_ON    = 4'd10,
    OP_SW2_OFF   = 4'd11
  } opcode_t;

  // Run states.
  typedef enum logic [1:0] {
    RUN_DISCONNECTED = 2'd0,
    RUN_IDLE         = 2'd1,
    RUN_OFFSET       = 2'd2,
    RUN_EXPOSURE     = 2'd3
  } run_t;

  // Image phases.
  typedef enum logic [2:0] {
    PH_PREPARE = 3'd0,
    PH_SW1_ON  = 3'd1,
    PH_SW2_ON  = 3'd2,
    PH_SHOT_GO = 3'd3,
    PH_DATA    = 3'd4,
    PH_SW1_OFF = 3'd5
  } phase_t;

  // Switch and shot command codes.
  localparam logic [1:0] CMD_NONE = 2'd0;
  localparam logic [1:0] CMD_ON   = 2'd1;
  localparam logic [1:0] CMD_OFF  = 2'd2;

  // Prepare command codes.
  localparam logic [1:0] PREP_NONE     = 2'd0;
  localparam logic [1:0] PREP_OFFSET   = 2'd1;
  localparam logic [1:0] PREP_EXPOSURE = 2'd2;

  // Run result codes.
  localparam logic [1:0] RC_NONE    = 2'd0;
  localparam logic [1:0] RC_DONE    = 2'd1;
  localparam logic [1:0] RC_REFUSED = 2'd2;

  // Image type codes.
  localparam logic [1:0] IT_OFFSET   = 2'd0;
  localparam logic [1:0] IT_EXPOSURE = 2'd1;
  localparam logic [1:0] IT_BOTH     = 2'd2;

  // Detector numbers.
  localparam logic [1:0] DET_MAIN   = 2'd1;
  localparam logic [1:0] DET_SECOND = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_IMAGE_TYPE    = 2'd0;
  localparam logic [1:0] REG_IMAGE_TARGET  = 2'd1;
  localparam logic [1:0] REG_BOX_ENABLE    = 2'd2;
  localparam logic [1:0] REG_TIMEOUT_TICKS = 2'd3;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  // Register reset values.
  localparam logic [1:0]  IMAGE_TYPE_RESET    = IT_EXPOSURE;
  localparam logic [9:0]  IMAGE_TARGET_RESET  = 10'd1;
  localparam logic        BOX_ENABLE_RESET    = 1'b0;
  localparam logic [15:0] TIMEOUT_TICKS_RESET = 16'd1000;

  typedef struct packed {
    logic [1:0]  image_type;
    logic [9:0]  image_target;
    logic        box_enable;
    logic [15:0] timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic [3:0] opcode;
    logic [1:0] detector;
  } in_word_t;

  typedef struct packed {
    logic [1:0] run_state;
    logic [2:0] phase;
    logic [1:0] sw1_command;
    logic [1:0] sw2_command;
    logic [1:0] prepare_command;
    logic       read_command;
    logic [1:0] shot_command;
    logic       exposure_request;
    logic       connect_second;
    logic [9:0] image_index;
    logic       offset_pass_done;
    logic [1:0] result_code;
  } out_word_t;

endpackage

// File: design/ddes_core.sv
// Sequencer state and event decode for the dual detector exposure sequencer.
// Updates the run, phase, ready, counter and timer state for one event per cycle while step is high.
// Depends on ddes_pkg.
module ddes_core
  import ddes_pkg::*;
#(
  parameter int COUNT_BITS = 10
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      step,
  input  in_word_t  event_word,
  input  cfg_t      cfg,
  output out_word_t result
);

  localparam int CMP_W = (COUNT_BITS > 10) ? COUNT_BITS : 10;

  run_t                  run_reg, run_next;
  phase_t                phase_reg, phase_next;
  logic [1:0]            connected_flags, connected_next;
  logic [1:0]            ready_flags, ready_next;
  logic [COUNT_BITS-1:0] image_counter, counter_next;
  logic                  offset_done_flag, offset_done_next;
  logic [15:0]           timeout_counter, timeout_next;
  logic                  timer_running, timer_next;

  logic                  both_ready;
  logic                  offset_now;
  logic                  begin_image;
  logic [1:0]            ready_set;
  logic [CMP_W-1:0]      count_ext;
  logic [CMP_W-1:0]      target_ext;
  out_word_t             res;

  // Ready bit raised by a prepare-done or after-done event.
  always_comb begin
    ready_set = 2'b00;
    if (event_word.detector == DET_MAIN) begin
      ready_set = 2'b01;
    end else if (event_word.detector == DET_SECOND) begin
      ready_set = 2'b10;
    end
  end

  assign count_ext  = CMP_W'(counter_next);
  assign target_ext = CMP_W'(cfg.image_target);

  // Next state and result for the current event.
  always_comb begin
    run_next         = run_reg;
    phase_next       = phase_reg;
    connected_next   = connected_flags;
    ready_next       = ready_flags;
    counter_next     = image_counter;
    offset_done_next = offset_done_flag;
    timeout_next     = timeout_counter;
    timer_next       = timer_running;
    begin_image      = 1'b0;
    res              = '0;

    case (event_word.opcode)
      OP_TICK: begin
        if (timer_running) begin
          if (timeout_counter <= 16'd1) begin
            timeout_next = '0;
            timer_next   = 1'b0;
            if (run_reg == RUN_OFFSET && phase_reg == PH_SW1_ON) begin
              phase_next      = PH_SW2_ON;
              res.sw2_command = CMD_ON;
            end
          end else begin
            timeout_next = timeout_counter - 16'd1;
          end
        end
      end
      OP_START: begin
        if (run_reg == RUN_IDLE) begin
          counter_next     = '0;
          offset_done_next = 1'b0;
          begin_image      = 1'b1;
        end else if (connected_flags != 2'b11) begin
          res.result_code = RC_REFUSED;
        end
      end
      OP_CONNECT: begin
        if (event_word.detector == DET_MAIN && !connected_flags[0]) begin
          connected_next[0] = 1'b1;
          if (!connected_flags[1]) begin
            res.connect_second = 1'b1;
          end
        end else if (event_word.detector == DET_SECOND && !connected_flags[1]) begin
          connected_next[1] = 1'b1;
        end
        if (connected_next == 2'b11) begin
          run_next = RUN_IDLE;
        end
      end
      OP_PREP_DONE: begin
        ready_next = ready_flags | ready_set;
        if (run_reg == RUN_OFFSET && phase_reg == PH_PREPARE) begin
          if (ready_next == 2'b11) begin
            phase_next      = PH_SW1_ON;
            res.sw1_command = CMD_ON;
            timeout_next    = cfg.timeout_ticks;
            timer_next      = 1'b1;
          end
        end else if (run_reg == RUN_EXPOSURE && phase_reg == PH_PREPARE) begin
          if (ready_next == 2'b11 && cfg.box_enable) begin
            res.exposure_request = 1'b1;
          end
        end
      end
      OP_SHOT_ON: begin
        if ((run_reg == RUN_OFFSET || run_reg == RUN_EXPOSURE) && phase_reg == PH_SW2_ON) begin
          phase_next = PH_SHOT_GO;
          if (run_reg == RUN_EXPOSURE) begin
            res.shot_command = CMD_ON;
          end
        end
      end
      OP_SHOT_OFF: begin
        ready_next = 2'b00;
        if (run_reg == RUN_OFFSET && phase_reg == PH_SHOT_GO) begin
          res.sw2_command = CMD_OFF;
        end else if (run_reg == RUN_EXPOSURE && phase_reg == PH_SHOT_GO) begin
          res.shot_command = CMD_OFF;
        end
        phase_next       = PH_DATA;
        res.read_command = 1'b1;
      end
      OP_DATA_DONE: begin
        if (phase_reg == PH_SHOT_GO || phase_reg == PH_DATA) begin
          phase_next = PH_SW1_OFF;
          if (run_reg == RUN_OFFSET) begin
            res.sw1_command = CMD_OFF;
          end
        end
      end
      OP_AFTER: begin
        ready_next = ready_flags | ready_set;
        if (phase_reg == PH_SW1_OFF && ready_next == 2'b11) begin
          if (cfg.image_type == IT_BOTH && !offset_done_flag) begin
            offset_done_next = 1'b1;
          end else begin
            offset_done_next = 1'b0;
            counter_next     = image_counter + COUNT_BITS'(1);
          end
          if (target_ext > count_ext) begin
            begin_image = 1'b1;
          end else begin
            run_next        = RUN_IDLE;
            res.result_code = RC_DONE;
          end
        end
      end
      OP_SW1_ON: begin
        if (run_reg == RUN_EXPOSURE && phase_reg == PH_PREPARE) begin
          phase_next = PH_SW1_ON;
          if (both_ready) begin
            res.sw1_command = CMD_ON;
          end
        end
      end
      OP_SW2_ON: begin
        if (run_reg == RUN_EXPOSURE && phase_reg == PH_SW1_ON) begin
          phase_next      = PH_SW2_ON;
          res.sw2_command = CMD_ON;
        end
      end
      default: begin
      end
    endcase

    // Start of a new image: offset or exposure, as the image type and pass say.
    if (begin_image) begin
      ready_next = 2'b00;
      phase_next = PH_PREPARE;
      if (offset_now) begin
        run_next            = RUN_OFFSET;
        res.prepare_command = PREP_OFFSET;
      end else begin
        run_next            = RUN_EXPOSURE;
        res.prepare_command = PREP_EXPOSURE;
      end
    end

    res.run_state        = run_next;
    res.phase            = phase_next;
    res.image_index      = count_ext[9:0];
    res.offset_pass_done = offset_done_next;
  end

  assign both_ready = (ready_flags == 2'b11);
  assign offset_now = (cfg.image_type == IT_OFFSET) ||
                      (cfg.image_type == IT_BOTH && !offset_done_next);
  assign result     = res;

  // State registers, updated once for each accepted event.
  always_ff @(posedge clk) begin
    if (rst) begin
      run_reg          <= RUN_DISCONNECTED;
      phase_reg        <= PH_PREPARE;
      connected_flags  <= '0;
      ready_flags      <= '0;
      image_counter    <= '0;
      offset_done_flag <= 1'b0;
      timeout_counter  <= '0;
      timer_running    <= 1'b0;
    end else if (step) begin
      run_reg          <= run_next;
      phase_reg        <= phase_next;
      connected_flags  <= connected_next;
      ready_flags      <= ready_next;
      image_counter    <= counter_next;
      offset_done_flag <= offset_done_next;
      timeout_counter  <= timeout_next;
      timer_running    <= timer_next;
    end
  end

endmodule

// File: design/dual_detector_exposure_sequencer.sv
// Top level of the dual detector exposure sequencer.
// Holds the configuration registers, the event handshake and the result register.
// Depends on ddes_pkg and ddes_core.
//
//   channel   signals                          word
//   events    in_valid, in_ready, in_word      opcode, detector
//   results   out_valid, out_ready, out_word   status and commands, one per event
//   config    cfg_we, cfg_index, cfg_data      four registers, write only
//
// Each event is decoded combinationally and its result word is registered, so the
// result appears the cycle after the event is accepted, and one event is taken every cycle unless stalled.
// A result waiting for out_ready holds; a new event is taken in the cycle it is removed.
// Reset is synchronous; it clears all sequencer state and loads the register defaults.
module dual_detector_exposure_sequencer
  import ddes_pkg::*;
#(
  parameter int COUNT_BITS = 10
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  in_word_t               in_word,
  output logic                   out_valid,
  input  logic                   out_ready,
  output out_word_t              out_word,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t      cfg;
  out_word_t core_result;
  logic      step;

  // An event is taken when the result register is empty or being emptied.
  assign in_ready = !out_valid || out_ready;
  assign step     = in_valid && in_ready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_type    <= IMAGE_TYPE_RESET;
      cfg.image_target  <= IMAGE_TARGET_RESET;
      cfg.box_enable    <= BOX_ENABLE_RESET;
      cfg.timeout_ticks <= TIMEOUT_TICKS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_TYPE:    cfg.image_type    <= cfg_data[1:0];
        REG_IMAGE_TARGET:  cfg.image_target  <= cfg_data[9:0];
        REG_BOX_ENABLE:    cfg.box_enable    <= cfg_data[0];
        REG_TIMEOUT_TICKS: cfg.timeout_ticks <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  ddes_core #(
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .event_word (in_word),
    .cfg        (cfg),
    .result     (core_result)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_word <= core_result;
    end
  end

  // Every accepted event leaves a result word behind it.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted event produced no result");

  // A completed run always reports the idle state.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.result_code == RC_DONE |-> out_word.run_state == RUN_IDLE)
    else $error("run completion outside idle state");

  // A read command always leaves the phase at data receive.
  a_read_phase: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.read_command |-> out_word.phase == PH_DATA)
    else $error("read command outside data receive phase");

  // A prepare command always starts an image in the prepare phase of a capture.
  a_prepare_phase: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.prepare_command != PREP_NONE |->
      out_word.phase == PH_PREPARE &&
      (out_word.run_state == RUN_OFFSET || out_word.run_state == RUN_EXPOSURE))
    else $error("prepare command outside a new image");

endmodule

// File: tb/sequencer_checker.sv
// Result checker for the dual detector exposure sequencer testbench.
// Mirrors the sequencer state from the event, result and register ports and compares results.
// Depends on ddes_pkg.
module sequencer_checker
  import ddes_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  in_word_t               in_word,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  out_word_t              out_word,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     mismatches,
  output int                     outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  // Mirrored registers and sequencer state.
  cfg_t       cfg_q;
  run_t       run_q;
  phase_t     phase_q;
  logic [1:0] linked_q;
  logic [1:0] armed_q;
  logic [9:0] frames_q;
  logic       offset_half_q;
  logic [15:0] timer_q;
  logic       timer_on_q;

  // Predicted result words, oldest first.
  out_word_t  status_due[$];

  // Starts the next image: offset for offset-only runs and for the first half of a
  // combined image, exposure otherwise. Returns the prepare command it issues.
  function automatic logic [1:0] open_image();
    logic offset_now;
    offset_now = (cfg_q.image_type == IT_OFFSET) ||
                 (cfg_q.image_type == IT_BOTH && !offset_half_q);
    armed_q = 2'b00;
    phase_q = PH_PREPARE;
    run_q   = offset_now ? RUN_OFFSET : RUN_EXPOSURE;
    return offset_now ? PREP_OFFSET : PREP_EXPOSURE;
  endfunction

  // Detector numbers outside one and two set no ready flag.
  function automatic void mark_ready(logic [1:0] det);
    if (det == DET_MAIN) armed_q[0] = 1'b1;
    else if (det == DET_SECOND) armed_q[1] = 1'b1;
  endfunction

  // Applies one event word to the mirrored state and returns the result word it causes.
  function automatic out_word_t predict_status(in_word_t w);
    out_word_t r;
    r = '0;
    case (w.opcode)
      OP_TICK: begin
        // One-shot timer; it moves an offset image from switch 1 to switch 2.
        if (timer_on_q) begin
          if (timer_q <= 16'd1) begin
            timer_q    = '0;
            timer_on_q = 1'b0;
            if (run_q == RUN_OFFSET && phase_q == PH_SW1_ON) begin
              phase_q = PH_SW2_ON;
              r.sw2_command = CMD_ON;
            end
          end else begin
            timer_q = timer_q - 16'd1;
          end
        end
      end
      OP_START: begin
        if (run_q == RUN_IDLE) begin
          frames_q      = '0;
          offset_half_q = 1'b0;
          r.prepare_command = open_image();
        end else if (linked_q != 2'b11) begin
          r.result_code = RC_REFUSED;
        end
      end
      OP_CONNECT: begin
        if (w.detector == DET_MAIN && !linked_q[0]) begin
          linked_q[0] = 1'b1;
          if (!linked_q[1]) r.connect_second = 1'b1;
        end else if (w.detector == DET_SECOND && !linked_q[1]) begin
          linked_q[1] = 1'b1;
        end
        if (linked_q == 2'b11) run_q = RUN_IDLE;
      end
      OP_PREP_DONE: begin
        mark_ready(w.detector);
        if (run_q == RUN_OFFSET && phase_q == PH_PREPARE) begin
          if (armed_q == 2'b11) begin
            phase_q       = PH_SW1_ON;
            r.sw1_command = CMD_ON;
            timer_q       = cfg_q.timeout_ticks;
            timer_on_q    = 1'b1;
          end
        end else if (run_q == RUN_EXPOSURE && phase_q == PH_PREPARE) begin
          if (armed_q == 2'b11 && cfg_q.box_enable) r.exposure_request = 1'b1;
        end
      end
      OP_SHOT_ON: begin
        if ((run_q == RUN_OFFSET || run_q == RUN_EXPOSURE) && phase_q == PH_SW2_ON) begin
          phase_q = PH_SHOT_GO;
          if (run_q == RUN_EXPOSURE) r.shot_command = CMD_ON;
        end
      end
      OP_SHOT_OFF: begin
        // Shot off forces the data phase and a read whatever the state.
        armed_q = 2'b00;
        if (run_q == RUN_OFFSET && phase_q == PH_SHOT_GO) r.sw2_command = CMD_OFF;
        else if (run_q == RUN_EXPOSURE && phase_q == PH_SHOT_GO) r.shot_command = CMD_OFF;
        phase_q        = PH_DATA;
        r.read_command = 1'b1;
      end
      OP_DATA_DONE: begin
        if (phase_q == PH_SHOT_GO || phase_q == PH_DATA) begin
          phase_q = PH_SW1_OFF;
          if (run_q == RUN_OFFSET) r.sw1_command = CMD_OFF;
        end
      end
      OP_AFTER: begin
        // Image bookkeeping runs even outside a run once both detectors report in the switch 1 off phase.
        mark_ready(w.detector);
        if (phase_q == PH_SW1_OFF && armed_q == 2'b11) begin
          if (cfg_q.image_type == IT_BOTH && !offset_half_q) begin
            offset_half_q = 1'b1;
          end else begin
            offset_half_q = 1'b0;
            frames_q      = frames_q + 10'd1;
          end
          if (cfg_q.image_target > frames_q) begin
            r.prepare_command = open_image();
          end else begin
            run_q         = RUN_IDLE;
            r.result_code = RC_DONE;
          end
        end
      end
      OP_SW1_ON: begin
        if (run_q == RUN_EXPOSURE && phase_q == PH_PREPARE) begin
          phase_q = PH_SW1_ON;
          if (armed_q == 2'b11) r.sw1_command = CMD_ON;
        end
      end
      OP_SW2_ON: begin
        if (run_q == RUN_EXPOSURE && phase_q == PH_SW1_ON) begin
          phase_q       = PH_SW2_ON;
          r.sw2_command = CMD_ON;
        end
      end
      default: begin
      end
    endcase
    r.run_state        = run_q;
    r.phase            = phase_q;
    r.image_index      = frames_q;
    r.offset_pass_done = offset_half_q;
    return r;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Results are compared before new words are predicted, so a stray result never
  // meets an expectation made in the same cycle.
  always @(posedge clk) begin : monitor
    out_word_t want;
    if (rst) begin
      cfg_q.image_type    = IMAGE_TYPE_RESET;
      cfg_q.image_target  = IMAGE_TARGET_RESET;
      cfg_q.box_enable    = BOX_ENABLE_RESET;
      cfg_q.timeout_ticks = TIMEOUT_TICKS_RESET;
      run_q         = RUN_DISCONNECTED;
      phase_q       = PH_PREPARE;
      linked_q      = 2'b00;
      armed_q       = 2'b00;
      frames_q      = '0;
      offset_half_q = 1'b0;
      timer_q       = '0;
      timer_on_q    = 1'b0;
      status_due.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (status_due.size() == 0) begin
          $display("%0t: result word %h arrived with nothing expected", $time, out_word);
          mismatches++;
        end else begin
          want = status_due.pop_front();
          check_field("run_state", want.run_state, out_word.run_state);
          check_field("phase", want.phase, out_word.phase);
          check_field("sw1_command", want.sw1_command, out_word.sw1_command);
          check_field("sw2_command", want.sw2_command, out_word.sw2_command);
          check_field("prepare_command", want.prepare_command, out_word.prepare_command);
          check_field("read_command", want.read_command, out_word.read_command);
          check_field("shot_command", want.shot_command, out_word.shot_command);
          check_field("exposure_request", want.exposure_request, out_word.exposure_request);
          check_field("connect_second", want.connect_second, out_word.connect_second);
          check_field("image_index", want.image_index, out_word.image_index);
          check_field("offset_pass_done", want.offset_pass_done, out_word.offset_pass_done);
          check_field("result_code", want.result_code, out_word.result_code);
        end
      end
      // New predictions go to the back of the queue.
      if (in_valid && in_ready) status_due = {status_due, predict_status(in_word)};
      if (cfg_we) begin
        case (cfg_index)
          REG_IMAGE_TYPE:    cfg_q.image_type    = cfg_data[1:0];
          REG_IMAGE_TARGET:  cfg_q.image_target  = cfg_data[9:0];
          REG_BOX_ENABLE:    cfg_q.box_enable    = cfg_data[0];
          REG_TIMEOUT_TICKS: cfg_q.timeout_ticks = cfg_data;
          default: begin
          end
        endcase
      end
    end
    outstanding <= status_due.size();
  end

endmodule

// File: tb/tb.sv
// Top of the dual detector exposure sequencer testbench: clock, reset, event stimulus,
// register settings, result back-pressure and the verdict.
// Depends on ddes_pkg, dual_detector_exposure_sequencer and sequencer_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ddes_pkg::*;

  // Codes outside the documented ranges, used to reach the corner cases.
  localparam logic [1:0] IT_UNUSED   = 2'd3;
  localparam logic [1:0] DET_NONE    = 2'd0;
  localparam logic [1:0] DET_BAD     = 2'd3;
  localparam logic [3:0] OP_SPARE_LO = 4'd12;
  localparam logic [3:0] OP_SPARE_HI = 4'd15;

  localparam int NUM_PHASES   = 12;
  localparam int PHASE_ITEMS  = 160;
  localparam int HOLD_CYCLES  = 300;
  localparam int CYCLE_LIMIT  = 200000;

  logic                   clk;
  logic                   rst;
  logic                   in_valid;
  logic                   in_ready;
  in_word_t               in_word;
  logic                   out_valid;
  logic                   out_ready;
  out_word_t              out_word;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  int                     mismatches;
  int                     outstanding;

  // Stimulus controls shared by the sender and the receiver.
  logic        quiet;
  logic        hold_now;
  int unsigned sent;
  int unsigned cycles;
  cfg_t        cfg_now;

  dual_detector_exposure_sequencer u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
    .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  sequencer_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
    .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Result side: random stalls, none while quiet, and one long hold-off on request.
  initial begin
    logic held;
    out_ready = 1'b0;
    held      = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_now && !held) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ready <= quiet || ($urandom_range(99) >= 15);
      end
    end
  end

  // Run limit.
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic cfg_t make_cfg(logic [1:0] kind, logic [9:0] target, logic box,
                                    logic [15:0] ticks);
    cfg_t c;
    c.image_type    = kind;
    c.image_target  = target;
    c.box_enable    = box;
    c.timeout_ticks = ticks;
    return c;
  endfunction

  // Any detector number, valid or not.
  function automatic logic [1:0] any_det();
    return 2'($urandom_range(3));
  endfunction

  // Offers one event word, sometimes after a short gap, and returns at the edge
  // where the block takes it.
  task automatic offer_event(input logic [3:0] op, input logic [1:0] det);
    in_word_t w;
    w.opcode   = op;
    w.detector = det;
    if (!quiet && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  // One step of a well-formed sequence: now and then a stray word goes first,
  // and now and then the step itself is dropped.
  task automatic play_step(input logic [3:0] op, input logic [1:0] det);
    if ($urandom_range(99) < 8) offer_event(4'($urandom_range(15)), any_det());
    if ($urandom_range(99) >= 3) offer_event(op, det);
  endtask

  // Both detectors report the same event in random order.
  task automatic play_pair(input logic [3:0] op);
    logic first_main;
    first_main = 1'($urandom_range(1));
    play_step(op, first_main ? DET_MAIN : DET_SECOND);
    play_step(op, first_main ? DET_SECOND : DET_MAIN);
  endtask

  // One image as the detectors and the switch controller report it.
  task automatic capture_image(input logic offset_img);
    int unsigned n;
    play_pair(OP_PREP_DONE);
    if (offset_img) begin
      // Enough ticks to fire the timer when it is short, one more now and then.
      if (cfg_now.timeout_ticks == 16'd0) n = 1;
      else if (cfg_now.timeout_ticks > 16'd12) n = 12;
      else n = 32'(cfg_now.timeout_ticks);
      repeat (n + $urandom_range(1)) play_step(OP_TICK, any_det());
    end else begin
      play_step(OP_SW1_ON, any_det());
      play_step(OP_SW2_ON, any_det());
    end
    play_step(OP_SHOT_ON, any_det());
    play_step(OP_SHOT_OFF, any_det());
    play_step(OP_DATA_DONE, any_det());
    if ($urandom_range(9) == 0) play_step(OP_SW1_OFF, any_det());
    if ($urandom_range(9) == 0) play_step(OP_SW2_OFF, any_det());
    play_pair(OP_AFTER);
  endtask

  // A start followed by the images of one run; long targets are cut short.
  task automatic capture_run();
    int unsigned images;
    logic        offset_img;
    if ($urandom_range(19) == 0) play_step(OP_CONNECT, any_det());
    play_step(OP_START, any_det());
    if (cfg_now.image_target == 10'd0) images = 1;
    else if (cfg_now.image_target > 10'd4) images = 4;
    else images = 32'(cfg_now.image_target);
    if (cfg_now.image_type == IT_BOTH) images = images * 2;
    offset_img = (cfg_now.image_type == IT_OFFSET) || (cfg_now.image_type == IT_BOTH);
    repeat (images) begin
      capture_image(offset_img);
      if (cfg_now.image_type == IT_BOTH) offset_img = !offset_img;
    end
  endtask

  // Stops offering and waits until every expected result word has been taken.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes all four registers on consecutive edges.
  task automatic load_settings(input cfg_t c);
    cfg_we    <= 1'b1;
    cfg_index <= REG_IMAGE_TYPE;
    cfg_data  <= CFG_DATA_W'(c.image_type);
    @(posedge clk);
    cfg_index <= REG_IMAGE_TARGET;
    cfg_data  <= CFG_DATA_W'(c.image_target);
    @(posedge clk);
    cfg_index <= REG_BOX_ENABLE;
    cfg_data  <= CFG_DATA_W'(c.box_enable);
    @(posedge clk);
    cfg_index <= REG_TIMEOUT_TICKS;
    cfg_data  <= c.timeout_ticks;
    @(posedge clk);
    cfg_we  <= 1'b0;
    cfg_now = c;
  endtask

  initial begin
    cfg_t        c;
    int unsigned phase_end;
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_word   = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    quiet     = 1'b0;
    hold_now  = 1'b0;
    sent      = 0;
    cfg_now   = make_cfg(IMAGE_TYPE_RESET, IMAGE_TARGET_RESET, BOX_ENABLE_RESET,
                         TIMEOUT_TICKS_RESET);
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed part with the reset settings: refused start, spare opcodes, bad
    // detector numbers, connection, one full exposure image and the after-done
    // bookkeeping outside a run.
    offer_event(OP_START, DET_MAIN);
    offer_event(OP_TICK, DET_NONE);
    offer_event(OP_SPARE_HI, DET_BAD);
    offer_event(OP_SPARE_LO, DET_NONE);
    offer_event(OP_CONNECT, DET_NONE);
    offer_event(OP_CONNECT, DET_BAD);
    offer_event(OP_CONNECT, DET_MAIN);
    offer_event(OP_CONNECT, DET_MAIN);
    offer_event(OP_CONNECT, DET_SECOND);
    offer_event(OP_START, DET_SECOND);
    offer_event(OP_PREP_DONE, DET_BAD);
    offer_event(OP_PREP_DONE, DET_MAIN);
    offer_event(OP_PREP_DONE, DET_SECOND);
    offer_event(OP_SW1_ON, DET_MAIN);
    offer_event(OP_SW2_ON, DET_MAIN);
    offer_event(OP_SHOT_ON, DET_MAIN);
    offer_event(OP_START, DET_MAIN);
    offer_event(OP_SHOT_OFF, DET_MAIN);
    offer_event(OP_DATA_DONE, DET_MAIN);
    offer_event(OP_SW1_OFF, DET_MAIN);
    offer_event(OP_SW2_OFF, DET_BAD);
    offer_event(OP_AFTER, DET_MAIN);
    offer_event(OP_AFTER, DET_SECOND);
    offer_event(OP_SHOT_OFF, DET_SECOND);
    offer_event(OP_DATA_DONE, DET_SECOND);
    offer_event(OP_AFTER, DET_SECOND);
    offer_event(OP_AFTER, DET_MAIN);

    // Random runs under a series of settings, the extremes first.
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      case (p)
        0: c = make_cfg(IT_OFFSET, 10'd3, 1'b1, 16'd1);
        1: c = make_cfg(IT_BOTH, 10'd2, 1'b1, 16'd0);
        2: c = make_cfg(IT_EXPOSURE, 10'd4, 1'b1, 16'hFFFF);
        3: c = make_cfg(IT_UNUSED, 10'd2, 1'b0, 16'd5);
        4: c = make_cfg(IT_BOTH, 10'd1023, 1'b0, 16'd3);
        5: c = make_cfg(IT_OFFSET, 10'd0, 1'b1, 16'd2);
        6: c = make_cfg(IT_OFFSET, 10'd2, 1'b0, 16'hFFFF);
        default: begin
          c.image_type    = 2'($urandom_range(3));
          c.image_target  = ($urandom_range(7) == 0) ? 10'($urandom_range(1023))
                                                      : 10'($urandom_range(5, 1));
          c.box_enable    = 1'($urandom_range(1));
          c.timeout_ticks = ($urandom_range(9) == 0) ? 16'($urandom_range(65535))
                                                      : 16'($urandom_range(9, 1));
        end
      endcase
      load_settings(c);
      // One phase runs with no idling on either side; another starts with a long
      // result hold-off while words keep coming.
      quiet = (p == 3);
      if (p == 1) hold_now = 1'b1;
      phase_end = sent + PHASE_ITEMS;
      while (sent < phase_end) capture_run();
    end

    wait_drained();
    if (mismatches == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
